>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL that carries concurrent checks.
// Stands alone; included by the top level, cobs_frame_receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cobs frame receiver check failed");

// Consequent must hold in the cycle after the antecedent.
`define CFR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cobs frame receiver check failed");

`endif

>>> hw/rtl/cfr_pkg.sv
// Shared constants and control types of the COBS frame receiver.
// No dependencies; used by the interfaces, controller, datapath and top level.
package cfr_pkg;

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;

   localparam logic [CSR_AW-1:0] CSR_MSG_LENGTH   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_CHECK_ENABLE = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_START_LENGTH = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_START_BYTES  = 2'd3;

   localparam int MSG_LENGTH_W   = 6;
   localparam int START_LENGTH_W = 3;
   localparam int START_BYTES_W  = 32;
   localparam int BYTE_W         = 8;

   localparam logic [MSG_LENGTH_W-1:0]   MSG_LENGTH_RST   = 6'd8;
   localparam logic                      CHECK_ENABLE_RST = 1'b1;
   localparam logic [START_LENGTH_W-1:0] START_LENGTH_RST = 3'd0;
   localparam logic [START_BYTES_W-1:0]  START_BYTES_RST  = 32'd0;

   // Number of start bytes held in the start_bytes register.
   localparam int START_BYTES_HELD = 4;

   localparam logic [BYTE_W-1:0] DELIM_BYTE = 8'h00;
   // Code value before the first code byte has been read.
   localparam logic [BYTE_W-1:0] CODE_NONE  = 8'hFF;

   typedef struct packed {
      logic take_byte;
      logic init_dec;
      logic run_dec;
      logic second;
   } cfr_cmd_type;

   typedef struct packed {
      logic delim_hit;
      logic produce;
      logic op_at_end;
      logic out_free;
   } cfr_status_type;

endpackage

>>> hw/rtl/cfr_req_if.sv
// Input channel of the COBS frame receiver: one received byte per transaction.
// Depends on cfr_pkg for the byte width.
interface cfr_req_if;
   import cfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);

endinterface

>>> hw/rtl/cfr_rsp_if.sv
// Result channel of the COBS frame receiver: one decoded byte per transaction.
// Depends on cfr_pkg for the byte width.
interface cfr_rsp_if;
   import cfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] msg_byte;
   logic              frame_ok;
   logic              last;

   modport source (output valid, output msg_byte, output frame_ok, output last, input ready);
   modport sink (input valid, input msg_byte, input frame_ok, input last, output ready);

endinterface

>>> hw/rtl/cfr_ram.sv
// Generic simple dual-port RAM: one write port and one registered read port.
// No dependencies.
module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/cfr_ctrl.sv
// Controller of the COBS frame receiver: sequences byte intake and the two decode passes.
// Depends on cfr_pkg for the command and status types.
module cfr_ctrl import cfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfr_status_type sts,
   output cfr_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PRIME1 = 3'd1;
   localparam logic [2:0] ST_PASS1  = 3'd2;
   localparam logic [2:0] ST_PRIME2 = 3'd3;
   localparam logic [2:0] ST_PASS2  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The first pass only sums the decoded bytes for the checksum; the second
   // pass decodes the same store again and hands the bytes out.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take_byte = 1'b1;
            if (sts.delim_hit) begin
               state_in = ST_PRIME1;
            end
         end
         ST_PRIME1: begin
            cmd.init_dec = 1'b1;
            state_in     = ST_PASS1;
         end
         ST_PASS1: begin
            cmd.run_dec = 1'b1;
            if (sts.produce && sts.op_at_end) begin
               state_in = ST_PRIME2;
            end
         end
         ST_PRIME2: begin
            cmd.init_dec = 1'b1;
            cmd.second   = 1'b1;
            state_in     = ST_PASS2;
         end
         ST_PASS2: begin
            cmd.run_dec = 1'b1;
            cmd.second  = 1'b1;
            if (sts.produce && sts.op_at_end && sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/cfr_datapath.sv
// Datapath of the COBS frame receiver: registers, start matching, frame store,
// COBS decoder, checksum and output register. Depends on cfr_pkg and cfr_ram.
module cfr_datapath import cfr_pkg::*; #(
   parameter int MAX_MSG_LEN   = 60,
   parameter int MAX_START_LEN = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_wdata,
   input  logic                req_valid,
   input  logic [BYTE_W-1:0]   rx_byte,
   input  cfr_cmd_type         cmd,
   output cfr_status_type      sts,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [BYTE_W-1:0]   msg_byte,
   output logic                frame_ok,
   output logic                last
);

   localparam int DEPTH = MAX_MSG_LEN + 3;
   localparam int AW    = $clog2(DEPTH);
   localparam int MW    = $clog2(MAX_START_LEN + 1);

   logic [MSG_LENGTH_W-1:0]   msg_length_ff;
   logic                      check_enable_ff;
   logic [START_LENGTH_W-1:0] start_length_ff;
   logic [START_BYTES_W-1:0]  start_bytes_ff;

   logic [AW-1:0]     eff_len;
   logic [MW-1:0]     eff_slen;
   logic [AW-1:0]     limit;
   logic [BYTE_W-1:0] exp_byte;

   logic [MW-1:0]     match_ff, match_in;
   logic [AW-1:0]     fill_ff, fill_in;
   logic              accept, collecting, hunting, fill_room;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [DEPTH-1:0]  valid_ff;
   logic              rd_valid_ff;
   logic [BYTE_W-1:0] rd_q;

   logic [AW-1:0]     ip_ff, ip_in;
   logic [AW-1:0]     op_ff, op_in;
   logic [BYTE_W-1:0] block_ff, block_in;
   logic [BYTE_W-1:0] code_ff, code_in;
   logic              done_ff, done_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic              ip_last;
   logic [BYTE_W-1:0] src_byte;
   logic              produce;
   logic [BYTE_W-1:0] dec_byte;
   logic [AW-1:0]     target;
   logic              op_at_end;
   logic              out_free;
   logic              advance;
   logic              load_out;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] msg_byte_ff;
   logic              ok_ff;
   logic              last_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         msg_length_ff   <= MSG_LENGTH_RST;
         check_enable_ff <= CHECK_ENABLE_RST;
         start_length_ff <= START_LENGTH_RST;
         start_bytes_ff  <= START_BYTES_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MSG_LENGTH:   msg_length_ff   <= csr_wdata[MSG_LENGTH_W-1:0];
            CSR_CHECK_ENABLE: check_enable_ff <= csr_wdata[0];
            CSR_START_LENGTH: start_length_ff <= csr_wdata[START_LENGTH_W-1:0];
            CSR_START_BYTES:  start_bytes_ff  <= csr_wdata[START_BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (msg_length_ff == '0) begin
         eff_len = AW'(1);
      end else if (32'(msg_length_ff) > 32'(MAX_MSG_LEN)) begin
         eff_len = AW'(MAX_MSG_LEN);
      end else begin
         eff_len = AW'(msg_length_ff);
      end
      if (32'(start_length_ff) > 32'(MAX_START_LEN)) begin
         eff_slen = MW'(MAX_START_LEN);
      end else begin
         eff_slen = MW'(start_length_ff);
      end
   end

   // Store position of the delimiter; the frame's bytes fill the positions below it.
   assign limit = eff_len + AW'(check_enable_ff) + AW'(1);

   // Start bytes beyond those held in the register compare as zero.
   always_comb begin
      exp_byte = DELIM_BYTE;
      for (int k = 0; k < START_BYTES_HELD; k++) begin
         if (32'(match_ff) == k) begin
            exp_byte = start_bytes_ff[8*k +: 8];
         end
      end
   end

   assign accept     = req_valid && cmd.take_byte;
   assign collecting = match_ff == eff_slen;
   assign hunting    = match_ff < eff_slen;
   assign fill_room  = fill_ff < limit;

   always_comb begin
      match_in = match_ff;
      fill_in  = fill_ff;
      wr_en    = 1'b0;
      wr_addr  = fill_ff;
      wr_data  = rx_byte;
      if (accept) begin
         if (collecting) begin
            if (fill_room) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + AW'(1);
            end else begin
               match_in = '0;
               fill_in  = AW'(1);
            end
         end else if (hunting) begin
            if (rx_byte == exp_byte) begin
               match_in = match_ff + MW'(1);
            end else begin
               // A mismatching byte becomes the lead code, less the start length.
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = rx_byte - BYTE_W'(eff_slen);
               match_in = '0;
               fill_in  = AW'(1);
            end
         end else begin
            match_in = '0;
            fill_in  = AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
         fill_ff  <= AW'(1);
         valid_ff <= '0;
      end else begin
         match_ff <= match_in;
         fill_ff  <= fill_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   cfr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ip_in),
      .rd_data (rd_q)
   );

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[ip_in];
   end

   // The framed byte at the delimiter position is always taken as zero.
   assign ip_last  = ip_ff == limit;
   assign src_byte = (ip_last || !rd_valid_ff) ? DELIM_BYTE : rd_q;

   // One decoder step gives at most one decoded byte. Once decoding has
   // stopped, the remaining decoded bytes are zero.
   always_comb begin
      produce  = 1'b0;
      dec_byte = DELIM_BYTE;
      if (done_ff) begin
         produce = 1'b1;
      end else if (block_ff != '0) begin
         produce  = 1'b1;
         dec_byte = src_byte;
      end else begin
         produce = (src_byte != DELIM_BYTE) && (code_ff != CODE_NONE);
      end
   end

   assign target    = cmd.second ? eff_len - AW'(1) : eff_len;
   assign op_at_end = op_ff == target;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = cmd.run_dec && !(cmd.second && produce && !out_free);
   assign load_out  = cmd.run_dec && cmd.second && produce && out_free;

   always_comb begin
      sts.delim_hit = accept && collecting && !fill_room && (rx_byte == DELIM_BYTE);
      sts.produce   = cmd.run_dec && produce;
      sts.op_at_end = op_at_end;
      sts.out_free  = out_free;
   end

   always_comb begin
      ip_in    = ip_ff;
      op_in    = op_ff;
      block_in = block_ff;
      code_in  = code_ff;
      done_in  = done_ff;
      acc_in   = acc_ff;
      if (cmd.init_dec) begin
         ip_in    = '0;
         op_in    = '0;
         block_in = '0;
         code_in  = CODE_NONE;
         done_in  = 1'b0;
         if (!cmd.second) begin
            acc_in = '0;
         end
      end else if (advance) begin
         if (produce) begin
            op_in = op_ff + AW'(1);
            if (!cmd.second) begin
               // The byte after the payload is the checksum; payload bytes subtract.
               acc_in = (op_ff == eff_len) ? acc_ff + dec_byte : acc_ff - dec_byte;
            end
         end
         if (!done_ff) begin
            if (ip_last) begin
               done_in = 1'b1;
            end else begin
               ip_in = ip_ff + AW'(1);
            end
            if (block_ff != '0) begin
               block_in = block_ff - 8'd1;
            end else begin
               code_in = src_byte;
               if (src_byte == DELIM_BYTE) begin
                  done_in = 1'b1;
               end else begin
                  block_in = src_byte - 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ip_ff    <= ip_in;
      op_ff    <= op_in;
      block_ff <= block_in;
      code_ff  <= code_in;
      done_ff  <= done_in;
      acc_ff   <= acc_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         msg_byte_ff <= dec_byte;
         last_ff     <= op_at_end;
         ok_ff       <= !check_enable_ff || (acc_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign msg_byte  = msg_byte_ff;
   assign frame_ok  = ok_ff;
   assign last      = last_ff;

endmodule

>>> hw/rtl/cobs_frame_receiver.sv
// COBS frame receiver top level: controller and datapath joined by command and status.
// Depends on cfr_pkg, cfr_req_if, cfr_rsp_if, cfr_ctrl, cfr_datapath and assert_macros.svh.
//
// Usage: req_ch carries one received byte per transaction. The block hunts for the
// start sequence, then collects msg_length bytes and, when checking is on, one
// checksum byte. A zero byte after that ends the frame; any other byte drops it.
// rsp_ch then carries msg_length decoded bytes, last set on the final one and
// frame_ok the same on all of them. csr_we, csr_index and csr_wdata write the
// registers msg_length, check_enable, start_length and start_bytes (index 0 to 3).
// Throughput: one received byte per cycle while hunting and collecting. After a
// good delimiter the frame store is decoded twice through its single read port:
// a checksum pass, then an output pass, one framed byte per cycle while the
// result channel does not stall. A stalled result channel holds the decoder, and
// the input stays closed until the last byte of the message sits in the output
// register.
// Reset is synchronous: registers return to their defaults, the frame store
// reads as all zero and the hunt starts afresh; no clearing pass is needed.
`include "assert_macros.svh"

module cobs_frame_receiver import cfr_pkg::*; #(
   parameter int MAX_MSG_LEN   = 60,
   parameter int MAX_START_LEN = 4
) (
   input  logic              clock,
   input  logic              reset,
   cfr_req_if.sink           req_ch,
   cfr_rsp_if.source         rsp_ch,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   cfr_cmd_type    cmd;
   cfr_status_type sts;
   logic           in_accept;

   cfr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   cfr_datapath #(
      .MAX_MSG_LEN   (MAX_MSG_LEN),
      .MAX_START_LEN (MAX_START_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_ch.valid),
      .rx_byte   (req_ch.rx_byte),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .msg_byte  (rsp_ch.msg_byte),
      .frame_ok  (rsp_ch.frame_ok),
      .last      (rsp_ch.last)
   );

   assign req_ch.ready = cmd.take_byte;
   assign in_accept    = req_ch.valid && req_ch.ready;

   // A good delimiter closes the input while the frame is decoded.
   `CFR_ASSERT_NXT(a_delim_closes_input, clock, reset, in_accept && sts.delim_hit, !req_ch.ready)

   // Results are only loaded during the output pass, never while bytes are taken.
   `CFR_ASSERT_NXT(a_idle_no_load, clock, reset, req_ch.ready && !rsp_ch.valid, !rsp_ch.valid)

   // A waiting result that is not the last one means the output pass is still running.
   `CFR_ASSERT_IMP(a_closed_mid_msg, clock, reset, rsp_ch.valid && !rsp_ch.last, !req_ch.ready)

endmodule
